>>> design/dds_pkg.sv
package dds_pkg;

  localparam int MAX_ITEMS_DEF = 16;
  localparam int DUR_W         = 12;

  typedef struct packed {
    logic [5:0] end_minute;
    logic [4:0] end_hour;
    logic [5:0] start_minute;
    logic [4:0] start_hour;
  } rec_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // (eh - sh) * 60 + (em - sm); times 60 as times 64 minus times 4
  function automatic logic signed [DUR_W-1:0] rec_duration(input rec_t r);
    logic signed [DUR_W-1:0] dh;
    logic signed [DUR_W-1:0] dm;
    dh = $signed({{(DUR_W-5){1'b0}}, r.end_hour}) -
         $signed({{(DUR_W-5){1'b0}}, r.start_hour});
    dm = $signed({{(DUR_W-6){1'b0}}, r.end_minute}) -
         $signed({{(DUR_W-6){1'b0}}, r.start_minute});
    return (dh <<< 6) - (dh <<< 2) + dm;
  endfunction

endpackage

>>> design/dds_cell.sv
module dds_cell import dds_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [CNT_W-1:0]        count,
  input  rec_t                    new_rec,
  input  logic signed [DUR_W-1:0] new_dur,
  input  logic                    left_keep,
  input  rec_t                    left_rec,
  input  logic signed [DUR_W-1:0] left_dur,
  input  rec_t                    right_rec,
  input  logic signed [DUR_W-1:0] right_dur,
  output rec_t                    rec,
  output logic signed [DUR_W-1:0] dur,
  output logic                    keep
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic occupied;

  assign occupied = MY_IDX < count;
  // equal durations stay ahead of the newcomer, which keeps arrival order
  assign keep     = occupied && (dur >= new_dur);

  always_ff @(posedge clk) begin
    if (ctl.ins && !keep) begin
      if (left_keep) begin
        rec <= new_rec;
        dur <= new_dur;
      end else begin
        rec <= left_rec;
        dur <= left_dur;
      end
    end else if (ctl.shift) begin
      rec <= right_rec;
      dur <= right_dur;
    end
  end

endmodule

>>> design/duration_descending_sorter.sv
// Duration sorter: collects job records and returns them longest first.
// Input channel: in_valid/in_stall with start and end time in hours and
// minutes and last_item. Each accepted word is inserted into a chain of
// sorting cells; a word arriving with the chain full is
// dropped. A word with last_item set closes the set.
// Output channel: out_valid/out_stall. After the closing word the chain
// drains from its head, one record per cycle unless out_stall holds it,
// each with its duration in minutes; last_result marks the final record.
// The state turns to drain once the closing word is accepted, and each
// record leaves through the output register. Throughput: one word per
// cycle while loading, one result per cycle while draining. in_stall is
// high for the whole drain; the output register holds its word while
// out_stall is high and the drain pauses with it.
// Reset empties the chain and clears out_valid.
module duration_descending_sorter import dds_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [4:0]              start_hour,
  input  logic [5:0]              start_minute,
  input  logic [4:0]              end_hour,
  input  logic [5:0]              end_minute,
  input  logic                    last_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [4:0]              out_start_hour,
  output logic [5:0]              out_start_minute,
  output logic [4:0]              out_end_hour,
  output logic [5:0]              out_end_minute,
  output logic signed [DUR_W-1:0] duration_minutes,
  output logic                    last_result
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  cell_ctl_t        ctl;
  logic             accept_in, take_out;
  rec_t             new_rec;
  logic signed [DUR_W-1:0] new_dur;

  rec_t                    c_rec  [MAX_ITEMS+1];
  logic signed [DUR_W-1:0] c_dur  [MAX_ITEMS+1];
  logic                    c_keep [MAX_ITEMS+1];

  assign new_rec = '{end_minute: end_minute, end_hour: end_hour,
                     start_minute: start_minute, start_hour: start_hour};
  assign new_dur = rec_duration(new_rec);

  assign in_stall  = (state == ST_DRAIN);
  assign accept_in = in_valid && !in_stall;
  assign take_out  = !out_valid || !out_stall;

  // spare slot past the tail feeds the last cell on a shift
  assign c_rec[MAX_ITEMS]  = '0;
  assign c_dur[MAX_ITEMS]  = '0;
  assign c_keep[MAX_ITEMS] = 1'b0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    rec_t                    l_rec;
    logic signed [DUR_W-1:0] l_dur;
    logic                    l_keep;
    if (i == 0) begin : g_head
      assign l_rec  = new_rec;
      assign l_dur  = new_dur;
      assign l_keep = 1'b1;
    end else begin : g_body
      assign l_rec  = c_rec[i-1];
      assign l_dur  = c_dur[i-1];
      assign l_keep = c_keep[i-1];
    end
    dds_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .new_rec   (new_rec),
      .new_dur   (new_dur),
      .left_keep (l_keep),
      .left_rec  (l_rec),
      .left_dur  (l_dur),
      .right_rec (c_rec[i+1]),
      .right_dur (c_dur[i+1]),
      .rec       (c_rec[i]),
      .dur       (c_dur[i]),
      .keep      (c_keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ctl.ins    = 1'b0;
    ctl.shift  = 1'b0;
    unique case (state)
      ST_LOAD: begin
        // drop the word when the chain is full
        ctl.ins = accept_in && (count < FULL);
        if (ctl.ins) count_next = count + ONE;
        if (accept_in && last_item) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        ctl.shift = take_out;
        if (take_out) begin
          count_next = count - ONE;
          if (count == ONE) state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.shift) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      out_start_hour   <= c_rec[0].start_hour;
      out_start_minute <= c_rec[0].start_minute;
      out_end_hour     <= c_rec[0].end_hour;
      out_end_minute   <= c_rec[0].end_minute;
      duration_minutes <= c_dur[0];
      last_result      <= (count == ONE);
    end
  end

endmodule

>>> sim/duration_descending_sorter_checker.sv
module duration_descending_sorter_checker import dds_pkg::*; #(
  parameter int CAPACITY = MAX_ITEMS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [4:0]              start_hour,
  input  logic [5:0]              start_minute,
  input  logic [4:0]              end_hour,
  input  logic [5:0]              end_minute,
  input  logic                    last_item,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [4:0]              out_start_hour,
  input  logic [5:0]              out_start_minute,
  input  logic [4:0]              out_end_hour,
  input  logic [5:0]              out_end_minute,
  input  logic signed [DUR_W-1:0] duration_minutes,
  input  logic                    last_result,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    rec_t                    job;
    logic signed [DUR_W-1:0] minutes;
    logic                    closing;
  } ranked_job_t;

  rec_t        held_jobs [CAPACITY];
  int          held_count;
  ranked_job_t ranked_q [$];

  function automatic logic signed [DUR_W-1:0] job_minutes(input rec_t r);
    int d;
    d = (int'(r.end_hour) - int'(r.start_hour)) * 60 +
        int'(r.end_minute) - int'(r.start_minute);
    return d[DUR_W-1:0];
  endfunction

  function automatic int field_differs(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // stable insertion by duration, longest first; equal durations keep arrival order
  task automatic rank_held_jobs();
    int                      slot [CAPACITY];
    logic signed [DUR_W-1:0] key [CAPACITY];
    logic signed [DUR_W-1:0] d;
    int                      j;
    ranked_job_t             res;
    for (int i = 0; i < held_count; i++) begin
      d = job_minutes(held_jobs[i]);
      j = i;
      while (j > 0 && key[j-1] < d) begin
        key[j]  = key[j-1];
        slot[j] = slot[j-1];
        j--;
      end
      key[j]  = d;
      slot[j] = i;
    end
    for (int i = 0; i < held_count; i++) begin
      res.job     = held_jobs[slot[i]];
      res.minutes = key[i];
      res.closing = (i == held_count - 1);
      ranked_q.push_back(res);
    end
    held_count = 0;
  endtask

  always @(posedge clk) begin
    ranked_job_t want;
    int          bad;
    if (rst) begin
      held_count = 0;
      ranked_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (ranked_q.size() == 0) begin
          $error("result word with nothing expected: duration %0d", duration_minutes);
          fail_count++;
        end else begin
          want = ranked_q.pop_front();
          bad  = field_differs("out_start_hour", want.job.start_hour, out_start_hour);
          bad += field_differs("out_start_minute", want.job.start_minute, out_start_minute);
          bad += field_differs("out_end_hour", want.job.end_hour, out_end_hour);
          bad += field_differs("out_end_minute", want.job.end_minute, out_end_minute);
          bad += field_differs("duration_minutes", int'(want.minutes),
                               int'(duration_minutes));
          bad += field_differs("last_result", want.closing, last_result);
          fail_count += bad;
        end
      end
      if (in_valid && !in_stall) begin
        // drop the word once the store is full; a closing mark still counts
        if (held_count < CAPACITY) begin
          held_jobs[held_count] = {end_minute, end_hour, start_minute, start_hour};
          held_count++;
        end
        if (last_item)
          rank_held_jobs();
      end
    end
    pending = ranked_q.size();
  end

endmodule

>>> sim/tb_duration_descending_sorter.sv
module tb_duration_descending_sorter;
  timeunit 1ns;
  timeprecision 1ps;
  import dds_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [4:0]              start_hour = '0;
  logic [5:0]              start_minute = '0;
  logic [4:0]              end_hour = '0;
  logic [5:0]              end_minute = '0;
  logic                    last_item = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [4:0]              out_start_hour;
  logic [5:0]              out_start_minute;
  logic [4:0]              out_end_hour;
  logic [5:0]              out_end_minute;
  logic signed [DUR_W-1:0] duration_minutes;
  logic                    last_result;
  int                      fail_count;
  int                      pending;
  bit                      calm;

  always #5 clk = ~clk;

  duration_descending_sorter i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .start_hour       (start_hour),
    .start_minute     (start_minute),
    .end_hour         (end_hour),
    .end_minute       (end_minute),
    .last_item        (last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_start_hour   (out_start_hour),
    .out_start_minute (out_start_minute),
    .out_end_hour     (out_end_hour),
    .out_end_minute   (out_end_minute),
    .duration_minutes (duration_minutes),
    .last_result      (last_result)
  );

  duration_descending_sorter_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .start_hour       (start_hour),
    .start_minute     (start_minute),
    .end_hour         (end_hour),
    .end_minute       (end_minute),
    .last_item        (last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_start_hour   (out_start_hour),
    .out_start_minute (out_start_minute),
    .out_end_hour     (out_end_hour),
    .out_end_minute   (out_end_minute),
    .duration_minutes (duration_minutes),
    .last_result      (last_result),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    #2ms;
    $display("duration_descending_sorter verification failed");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_job(input logic [4:0] sh, input logic [5:0] sm,
                          input logic [4:0] eh, input logic [5:0] em, input logic closing);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start_hour   <= sh;
    start_minute <= sm;
    end_hour     <= eh;
    end_minute   <= em;
    last_item    <= closing;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // narrow picks crowd the durations together so ties are common
  function automatic logic [4:0] pick_hour(input bit narrow);
    if (narrow)
      return 5'($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0)
      return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, 23));
  endfunction

  function automatic logic [5:0] pick_minute(input bit narrow);
    if (narrow)
      return 6'($urandom_range(0, 3));
    if ($urandom_range(0, 7) == 0)
      return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 59));
  endfunction

  task automatic send_random_job(input bit narrow, input logic closing);
    send_job(pick_hour(narrow), pick_minute(narrow), pick_hour(narrow),
             pick_minute(narrow), closing);
  endtask

  // hold each result back for a drawn number of cycles in which it is on offer
  initial begin
    int hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) begin
          do @(posedge clk); while (!out_valid);
          @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  initial begin
    int sent;
    int set_len;
    bit narrow;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes, negative durations and a tie in one set
    send_job(5'd0, 6'd0, 5'd23, 6'd59, 1'b0);
    send_job(5'd23, 6'd59, 5'd0, 6'd0, 1'b0);
    send_job(5'd31, 6'd63, 5'd0, 6'd0, 1'b0);
    send_job(5'd0, 6'd0, 5'd31, 6'd63, 1'b0);
    send_job(5'd8, 6'd15, 5'd9, 6'd15, 1'b0);
    send_job(5'd10, 6'd0, 5'd11, 6'd0, 1'b0);
    send_job(5'd5, 6'd30, 5'd5, 6'd30, 1'b1);
    // set of one record
    send_job(5'd12, 6'd0, 5'd12, 6'd0, 1'b1);
    // overfill the store; the closing word itself is dropped
    for (int k = 0; k < 17; k++)
      send_random_job(1'b1, k == 16);

    sent = 25;
    while (sent < 410) begin
      set_len = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      narrow  = ($urandom_range(0, 3) == 0);
      calm    = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < set_len; k++)
        send_random_job(narrow, k == set_len - 1);
      sent += set_len;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("duration_descending_sorter verification clean");
    end else begin
      $display("duration_descending_sorter verification failed");
    end
    $finish;
  end

endmodule
